// ===== sv/b64d_pkg.sv =====
// Package with the base64url alphabet lookup and shared widths for the decoder.
`default_nettype none
package b64d_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned HeldW   = 3 * SextetW;
  localparam int unsigned WordW   = 4 * SextetW;

  typedef struct packed {
    logic               ok;
    logic [SextetW-1:0] val;
  } sextet_t;

  function automatic sextet_t map_char(input logic [CharW-1:0] c);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = SextetW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = SextetW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = SextetW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2D) begin
      r.val = SextetW'(62);
    end else if (c == 8'h5F) begin
      r.val = SextetW'(63);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/base64url_stream_decoder_unit.sv =====
// Streaming base64url decoder: input register, sextet packing and a result block register.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_char_i, final_char_i
// out      output     out_valid_o / out_stall_i out_byte_o, byte_valid_o,
//                                               end_of_message_o, bad_length_o
//
// One character is taken per cycle while in_stall_o is low.
// Characters that add no result pass the input register while the result register drains.
// A fourth sextet or a final character waits there until the last pending byte transfers,
// so a final character right after a full block pauses input transfers.
// Reset clears the sextet count, the held sextets and all valid flags.
// An output stall holds the result register and a block-loading input character.
`default_nettype none
module base64url_stream_decoder_unit
  import b64d_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [CharW-1:0] in_char_i,
  input  wire logic             final_char_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  byte_valid_o,
  output logic                  end_of_message_o,
  output logic                  bad_length_o
);

  logic             in_vld_q, in_vld_d;
  logic [CharW-1:0] in_char_q;
  logic             in_fin_q;

  logic [1:0]       sextet_count_q, sextet_count_d;
  logic [HeldW-1:0] held_q, held_d;

  logic [WordW-1:0] blk_word_q, blk_word_d;
  logic [1:0]       blk_cnt_q, blk_cnt_d;
  logic             blk_bv_q, blk_bv_d;
  logic             blk_eom_q, blk_eom_d;
  logic             blk_bad_q, blk_bad_d;

  logic             in_fire, out_fire, blk_free, need_blk, adv;
  sextet_t          sx;
  logic [WordW-1:0] acc;

  assign out_valid_o      = (blk_cnt_q != 2'd0);
  assign out_fire         = out_valid_o && !out_stall_i;
  assign blk_free         = (blk_cnt_q == 2'd0) || (blk_cnt_q == 2'd1 && out_fire);
  assign need_blk         = in_fin_q || (sx.ok && sextet_count_q == 2'd3);
  assign adv              = in_vld_q && (blk_free || !need_blk);
  assign in_stall_o       = in_vld_q && need_blk && !blk_free;
  assign in_fire          = in_valid_i && !in_stall_o;
  assign in_vld_d         = in_fire || (in_vld_q && !adv);

  assign out_byte_o       = blk_word_q[WordW-1 -: 8];
  assign byte_valid_o     = blk_bv_q;
  assign end_of_message_o = blk_eom_q && (blk_cnt_q == 2'd1);
  assign bad_length_o     = blk_bad_q;

  assign sx  = map_char(in_char_q);
  assign acc = {held_q, sx.val};

  always_comb begin
    sextet_count_d = sextet_count_q;
    held_d         = held_q;
    blk_word_d     = blk_word_q;
    blk_cnt_d      = blk_cnt_q;
    blk_bv_d       = blk_bv_q;
    blk_eom_d      = blk_eom_q;
    blk_bad_d      = blk_bad_q;
    if (out_fire) begin
      blk_word_d = {blk_word_q[WordW-9:0], 8'h00};
      blk_cnt_d  = blk_cnt_q - 2'd1;
    end
    if (adv) begin
      if (!sx.ok) begin
        if (in_fin_q) begin
          blk_word_d     = '0;
          blk_cnt_d      = 2'd1;
          blk_bv_d       = 1'b0;
          blk_eom_d      = 1'b1;
          blk_bad_d      = 1'b0;
          sextet_count_d = 2'd0;
          held_d         = '0;
        end
      end else if (!in_fin_q) begin
        if (sextet_count_q != 2'd3) begin
          sextet_count_d = sextet_count_q + 2'd1;
          held_d         = acc[HeldW-1:0];
        end else begin
          blk_word_d     = acc;
          blk_cnt_d      = 2'd3;
          blk_bv_d       = 1'b1;
          blk_eom_d      = 1'b0;
          blk_bad_d      = 1'b0;
          sextet_count_d = 2'd0;
          held_d         = '0;
        end
      end else begin
        sextet_count_d = 2'd0;
        held_d         = '0;
        blk_eom_d      = 1'b1;
        case (sextet_count_q)
          2'd0: begin
            blk_word_d = '0;
            blk_cnt_d  = 2'd1;
            blk_bv_d   = 1'b0;
            blk_bad_d  = 1'b1;
          end
          2'd1: begin
            blk_word_d = {acc[11:0], 12'h000};
            blk_cnt_d  = 2'd1;
            blk_bv_d   = 1'b1;
            blk_bad_d  = 1'b0;
          end
          2'd2: begin
            blk_word_d = {acc[17:0], 6'h00};
            blk_cnt_d  = 2'd2;
            blk_bv_d   = 1'b1;
            blk_bad_d  = 1'b0;
          end
          default: begin
            blk_word_d = acc;
            blk_cnt_d  = 2'd3;
            blk_bv_d   = 1'b1;
            blk_bad_d  = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      sextet_count_q <= 2'd0;
      held_q         <= '0;
      blk_cnt_q      <= 2'd0;
      blk_bv_q       <= 1'b0;
      blk_eom_q      <= 1'b0;
      blk_bad_q      <= 1'b0;
    end else begin
      in_vld_q       <= in_vld_d;
      sextet_count_q <= sextet_count_d;
      held_q         <= held_d;
      blk_cnt_q      <= blk_cnt_d;
      blk_bv_q       <= blk_bv_d;
      blk_eom_q      <= blk_eom_d;
      blk_bad_q      <= blk_bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_word_q <= blk_word_d;
    if (in_fire) begin
      in_char_q <= in_char_i;
      in_fin_q  <= final_char_i;
    end
  end

  a_marker_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> blk_cnt_q == 2'd1 && end_of_message_o)
    else $error("end marker shares the result register with data bytes");

  a_bad_is_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_length_o |-> !byte_valid_o)
    else $error("bad length flagged on a data byte");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_fin_q |=> sextet_count_q == 2'd0 && held_q == '0)
    else $error("state not cleared after a final character");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_cnt_q > 2'd1 || (blk_cnt_q == 2'd1 && out_stall_i) |-> !(adv && need_blk))
    else $error("new block loaded over pending results");

endmodule
`default_nettype wire
